@@ sv/dcd_pkg.sv @@
package dcd_pkg;

	// Field widths of the result word.
	localparam int YEAR_W = 14;
	localparam int MONTH_W = 4;
	localparam int DOM_W = 5;
	localparam int WDAY_W = 3;

	// Calendar constants.
	localparam logic [17:0] DAYS_400Y = 18'd146097;
	localparam logic [YEAR_W-1:0] YEAR_BASE = 14'd2000;
	localparam logic [YEAR_W-1:0] YEARS_PER_CYCLE = 14'd400;
	localparam logic [WDAY_W-1:0] WEEKDAY_BASE = 3'd6;
	localparam logic [8:0] DAYS_LEAP = 9'd366;
	localparam logic [8:0] DAYS_COMMON = 9'd365;
	localparam logic [6:0] CENTURY_LAST = 7'd99;
	localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd11;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step_cycle;
		logic step_year;
		logic step_month;
		logic publish;
	} dcd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cycle_ge;
		logic year_ge;
		logic month_ge;
		logic last_month;
	} dcd_stat_t;

	// Length of a month, indexed from 0 for January.
	function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] mon, input logic leap);
		logic [4:0] len;
		unique case (mon)
			4'd1: len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// Reduce a value below 37 modulo 7 by three conditional subtractions.
	function automatic logic [WDAY_W-1:0] mod7(input logic [5:0] x);
		logic [5:0] v;
		v = x;
		if (v >= 6'd28) v = v - 6'd28;
		if (v >= 6'd14) v = v - 6'd14;
		if (v >= 6'd7) v = v - 6'd7;
		return v[WDAY_W-1:0];
	endfunction

endpackage

@@ sv/dcd_count_if.sv @@
interface dcd_count_if #(
	parameter int COUNT_BITS = 22
);
	logic valid;
	logic ready;
	logic [COUNT_BITS-1:0] day_count;

	modport source (output valid, output day_count, input ready);
	modport sink (input valid, input day_count, output ready);
endinterface

@@ sv/dcd_date_if.sv @@
interface dcd_date_if import dcd_pkg::*; ();
	logic valid;
	logic ready;
	logic [YEAR_W-1:0] year;
	logic [MONTH_W-1:0] month;
	logic [DOM_W-1:0] day_of_month;
	logic [WDAY_W-1:0] weekday;

	modport source (output valid, output year, output month, output day_of_month,
		output weekday, input ready);
	modport sink (input valid, input year, input month, input day_of_month,
		input weekday, output ready);
endinterface

@@ sv/dcd_datapath.sv @@
module dcd_datapath import dcd_pkg::*; #(
	parameter int COUNT_BITS = 22
) (
	input logic clk,
	input logic [COUNT_BITS-1:0] day_count,
	input dcd_cmd_t cmd,
	output dcd_stat_t stat,
	output logic [YEAR_W-1:0] year,
	output logic [MONTH_W-1:0] month,
	output logic [DOM_W-1:0] day_of_month,
	output logic [WDAY_W-1:0] weekday
);

	localparam int CMP_W = (COUNT_BITS > 18) ? COUNT_BITS : 18;

	logic [COUNT_BITS-1:0] rem_q;
	logic [YEAR_W-1:0] year_q;
	logic [8:0] off_q;
	logic [6:0] c100_q;
	logic [WDAY_W-1:0] wd_q;
	logic [MONTH_W-1:0] mon_q;

	logic [YEAR_W-1:0] out_year_q;
	logic [MONTH_W-1:0] out_month_q;
	logic [DOM_W-1:0] out_dom_q;
	logic [WDAY_W-1:0] out_wday_q;

	logic [CMP_W-1:0] rem_x;
	logic leap;
	logic [8:0] year_len;
	logic [4:0] mon_len;
	logic [2:0] mon_shift;

	// Leap rule on the year offset within the 400-year cycle.
	assign leap = ((off_q[1:0] == 2'd0) && (c100_q != 7'd0)) || (off_q == 9'd0);
	assign year_len = leap ? DAYS_LEAP : DAYS_COMMON;
	assign mon_len = month_len(mon_q, leap);
	// Weekday advance of a whole month: its length modulo 7.
	assign mon_shift = mon_len[2:0] - 3'd4;

	assign rem_x = CMP_W'(rem_q);

	always_comb begin
		stat.cycle_ge = rem_x >= CMP_W'(DAYS_400Y);
		stat.year_ge = rem_x >= CMP_W'(year_len);
		stat.month_ge = rem_x >= CMP_W'(mon_len);
		stat.last_month = mon_q == LAST_MONTH;
	end

	// Working registers: remaining days and the date built up so far.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= day_count;
			year_q <= YEAR_BASE;
			off_q <= 9'd0;
			c100_q <= 7'd0;
			wd_q <= WEEKDAY_BASE;
			mon_q <= '0;
		end else if (cmd.step_cycle) begin
			// A 400-year cycle is a whole number of weeks.
			rem_q <= COUNT_BITS'(rem_x - CMP_W'(DAYS_400Y));
			year_q <= year_q + YEARS_PER_CYCLE;
		end else if (cmd.step_year) begin
			rem_q <= COUNT_BITS'(rem_x - CMP_W'(year_len));
			year_q <= year_q + 14'd1;
			off_q <= off_q + 9'd1;
			c100_q <= (c100_q == CENTURY_LAST) ? 7'd0 : c100_q + 7'd1;
			wd_q <= mod7({3'd0, wd_q} + (leap ? 6'd2 : 6'd1));
		end else if (cmd.step_month) begin
			rem_q <= COUNT_BITS'(rem_x - CMP_W'(mon_len));
			mon_q <= mon_q + 4'd1;
			wd_q <= mod7({3'd0, wd_q} + {3'd0, mon_shift});
		end
	end

	// Output register holding the finished word.
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_year_q <= year_q;
			out_month_q <= mon_q + 4'd1;
			out_dom_q <= rem_q[DOM_W-1:0] + 5'd1;
			out_wday_q <= mod7({3'd0, wd_q} + {1'b0, rem_q[DOM_W-1:0]});
		end
	end

	assign year = out_year_q;
	assign month = out_month_q;
	assign day_of_month = out_dom_q;
	assign weekday = out_wday_q;

endmodule

@@ sv/dcd_ctrl.sv @@
module dcd_ctrl import dcd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input dcd_stat_t stat,
	output dcd_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CYCLE,
		ST_YEAR,
		ST_MONTH,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	// Commands follow the state and the datapath status.
	always_comb begin
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.step_cycle = (state_q == ST_CYCLE) && stat.cycle_ge;
		cmd.step_year = (state_q == ST_YEAR) && stat.year_ge;
		cmd.step_month = (state_q == ST_MONTH) && stat.month_ge && !stat.last_month;
		cmd.publish = (state_q == ST_FINISH) && slot_free;
	end

	// State and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// The output word is raised on publish and dropped once it is taken.
			if (cmd.publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CYCLE;
				end
				ST_CYCLE: begin
					if (!stat.cycle_ge) state_q <= ST_YEAR;
				end
				ST_YEAR: begin
					if (!stat.year_ge) state_q <= ST_MONTH;
				end
				ST_MONTH: begin
					if (!stat.month_ge || stat.last_month) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ sv/day_count_to_date.sv @@
// Each accepted count is worked off in steps: first C, the number of whole 400-year cycles in
// the count, then Y (0..399) the remaining years and M (0..11) the months stripped; the word is
// then published once the output register is free.
// One word at a time: a new count is taken only once the previous word has been published.
// A finished word waits in the output register while the next count is taken.
// Reset (arst_n low) clears the controller and the output valid at once.
module day_count_to_date import dcd_pkg::*; #(
	parameter int COUNT_BITS = 22
) (
	input logic clk,
	input logic arst_n,
	dcd_count_if.sink count,
	dcd_date_if.source date
);

	dcd_cmd_t cmd;
	dcd_stat_t stat;
	logic [COUNT_BITS-1:0] day_count;

	assign day_count = count.day_count;

	dcd_ctrl u_ctrl (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (count.valid),
		.in_ready (count.ready),
		.out_valid (date.valid),
		.out_ready (date.ready),
		.stat (stat),
		.cmd (cmd)
	);

	dcd_datapath #(
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk (clk),
		.day_count (day_count),
		.cmd (cmd),
		.stat (stat),
		.year (date.year),
		.month (date.month),
		.day_of_month (date.day_of_month),
		.weekday (date.weekday)
	);

endmodule

@@ sv/dcd_checker.sv @@
module dcd_checker import dcd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [YEAR_W-1:0] year,
	input logic [MONTH_W-1:0] month,
	input logic [DOM_W-1:0] day_of_month,
	input logic [WDAY_W-1:0] weekday
);

	// A stalled output word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month)
			&& $stable(day_of_month) && $stable(weekday))
		else $error("output word changed while stalled");

	// After a count is taken the block is busy with it.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after an accepted count");

	// A word never appears in the cycle right after a count is taken.
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result word one cycle after acceptance");

	// Every delivered date lies in the calendar ranges.
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
			&& day_of_month <= 5'd31 && weekday <= 3'd6)
		else $error("date field out of range");

endmodule

bind day_count_to_date dcd_checker u_dcd_checker (
	.clk (clk),
	.arst_n (arst_n),
	.in_valid (count.valid),
	.in_ready (count.ready),
	.out_valid (date.valid),
	.out_ready (date.ready),
	.year (date.year),
	.month (date.month),
	.day_of_month (date.day_of_month),
	.weekday (date.weekday)
);
